>>> design/ppi_pkg.sv
// ----------------------------------------------------------------------------
// Planar pose integrator package
// Shared widths, constants and the arctangent table of the CORDIC unit.
// ----------------------------------------------------------------------------
package ppi_pkg;

    localparam int PosW  = 32;
    localparam int VelW  = 24;
    localparam int HdgW  = 16;
    localparam int QW    = 16;
    localparam int TimeW = 16;
    localparam int CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] REG_START_X   = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_START_Y   = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_START_HDG = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_DT_LIMIT  = 2'd3;

    localparam logic OP_INTEGRATE = 1'b0;
    localparam logic OP_RESTART   = 1'b1;

    // CORDIC angle and datapath width (Q16 radians, headroom for +-2pi)
    localparam int CordW   = 20;
    localparam int CordIter = 16;
    localparam int IterW   = 4;

    localparam logic signed [HdgW-1:0]  PI_Q13      = 16'sd25736;
    localparam logic signed [HdgW:0]    TWO_PI_Q13  = 17'sd51472;
    localparam logic signed [CordW-1:0] PI_Q16      = 20'sd205888;
    localparam logic signed [CordW-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [CordW-1:0] CORDIC_GAIN = 20'sd39797;
    localparam logic signed [QW-1:0]    ONE_Q14     = 16'sd16384;

    localparam logic signed [PosW-1:0] RST_START_X   = 32'sd0;
    localparam logic signed [PosW-1:0] RST_START_Y   = 32'sd0;
    localparam logic signed [HdgW-1:0] RST_START_HDG = -16'sd6434;
    localparam logic [TimeW-1:0]       RST_DT_LIMIT  = 16'd6554;

    function automatic logic signed [CordW-1:0] atan_q16(input logic [IterW-1:0] i);
        case (i)
            4'd0:  atan_q16 = 20'sd51472;
            4'd1:  atan_q16 = 20'sd30386;
            4'd2:  atan_q16 = 20'sd16055;
            4'd3:  atan_q16 = 20'sd8150;
            4'd4:  atan_q16 = 20'sd4091;
            4'd5:  atan_q16 = 20'sd2047;
            4'd6:  atan_q16 = 20'sd1024;
            4'd7:  atan_q16 = 20'sd512;
            4'd8:  atan_q16 = 20'sd256;
            4'd9:  atan_q16 = 20'sd128;
            4'd10: atan_q16 = 20'sd64;
            4'd11: atan_q16 = 20'sd32;
            4'd12: atan_q16 = 20'sd16;
            4'd13: atan_q16 = 20'sd8;
            4'd14: atan_q16 = 20'sd4;
            default: atan_q16 = 20'sd2;
        endcase
    endfunction

    typedef struct packed {
        logic                   opcode;
        logic signed [VelW-1:0] lin_vel_x;
        logic signed [VelW-1:0] lin_vel_y;
        logic signed [HdgW-1:0] yaw_rate;
        logic [TimeW-1:0]       elapsed;
    } t_in_item;

    typedef struct packed {
        logic signed [PosW-1:0] pos_x;
        logic signed [PosW-1:0] pos_y;
        logic signed [HdgW-1:0] heading;
        logic signed [QW-1:0]   quat_z;
        logic signed [QW-1:0]   quat_w;
        logic                   skipped;
    } t_out_item;

    typedef struct packed {
        logic [CfgIdxW-1:0] index;
        logic [PosW-1:0]    data;
    } t_cfg_item;

endpackage

>>> design/ppi_if.sv
// ----------------------------------------------------------------------------
// Planar pose integrator channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface ppi_in_if;
    logic               valid;
    logic               ready;
    ppi_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ppi_out_if;
    logic               valid;
    logic               ready;
    ppi_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ppi_cfg_if;
    logic               valid;
    logic               ready;
    ppi_pkg::t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/planar_pose_integrator_unit.sv
// ----------------------------------------------------------------------------
// Planar pose integrator
// Dead-reckoning of x, y and heading from body-frame velocity updates.
// ----------------------------------------------------------------------------
// An update runs the opcode check, then two 16-step CORDIC passes, each a
// start state and a wait for the done pulse. Between the passes each axis
// runs three multiply steps, two reciprocal-divide steps and one saturating
// add. The result load follows the second pass. A restart or a skipped
// update runs the second CORDIC pass only. The input is ready again once the
// result register is loaded, so a new update is taken only after the last one
// has finished. The result register is loaded only when it is empty or its
// transaction is being taken, so a stalled output holds the sequencer in its
// last state and blocks the input.
module planar_pose_integrator_unit (
    input  logic    i_clk,
    input  logic    i_rst_n,
    ppi_in_if.sink  in_ch,
    ppi_out_if.source out_ch,
    ppi_cfg_if.sink cfg_ch
);
    import ppi_pkg::*;

    localparam int ProdW = 64;
    localparam int AccW = VelW + QW + 1;
    localparam int TProdW = AccW + TimeW + 1;
    localparam int DivShift = 25;
    localparam int DivNW = 31;
    localparam int RecipW = 32;
    localparam int RecipShift = 38;
    localparam logic [ProdW-1:0]  HALF_DIV  = 64'd2097152000;
    localparam logic [RecipW-1:0] RECIP_125 = 32'd2199023256;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_CS1, S_WAIT1, S_MUL, S_DIV, S_HDG, S_CS2, S_WAIT2, S_OUT
    } t_state;

    t_state r_state;
    logic signed [PosW-1:0] r_start_x, r_start_y, r_pos_x, r_pos_y;
    logic signed [HdgW-1:0] r_start_hdg, r_hdg;
    logic [TimeW-1:0]       r_dt_limit;
    t_in_item               r_item;
    logic signed [QW-1:0]   r_sin, r_cos;
    logic [1:0]             r_mstep;
    logic signed [AccW-1:0] r_acc;
    logic                   r_axis;
    logic                   r_dstep;
    logic [ProdW-1:0]       r_num;
    logic                   r_dneg;
    logic                   r_skip;
    logic                   r_ovalid;
    t_out_item              r_out;

    logic                   w_cs_start;
    logic signed [CordW-1:0] w_cs_angle;
    logic                   w_cs_done;
    logic signed [QW-1:0]   w_sin, w_cos;

    ppi_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cs_start),
        .i_angle (w_cs_angle),
        .o_done  (w_cs_done),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    assign w_cs_start = (r_state == S_CS1) || (r_state == S_CS2);
    assign w_cs_angle = (r_state == S_CS1) ? (CordW'(r_hdg) <<< 3) : (CordW'(r_hdg) <<< 2);

    // Shared multiplier for velocity x trig; a second one for sum x elapsed
    logic signed [VelW-1:0]   w_ma;
    logic signed [QW-1:0]     w_mb;
    logic signed [VelW+QW-1:0] w_vprod;
    logic signed [TProdW-1:0] w_tprod;
    always_comb begin
        case (r_mstep)
            2'd0:    begin w_ma = r_item.lin_vel_x; w_mb = r_axis ? r_sin : r_cos; end
            2'd1:    begin w_ma = r_item.lin_vel_y; w_mb = r_axis ? r_cos : -r_sin; end
            default: begin w_ma = r_item.lin_vel_x; w_mb = r_cos; end
        endcase
    end
    assign w_vprod = w_ma * w_mb;
    assign w_tprod = r_acc * $signed({1'b0, r_item.elapsed});

    // Divide by 1000*2^22 = 125*2^25: add half, shift, then multiply by 1/125
    logic [ProdW-1:0]        w_dsum;
    logic [DivNW-1:0]        w_dn;
    logic [DivNW+RecipW-1:0] w_dprod;
    logic [DivNW+RecipW-RecipShift-1:0] w_dq;
    assign w_dsum  = r_num + HALF_DIV;
    assign w_dn    = w_dsum[DivShift +: DivNW];
    assign w_dprod = r_num[DivNW-1:0] * RECIP_125;
    assign w_dq    = w_dprod[DivNW+RecipW-1:RecipShift];

    // Heading step, wrap and clamp to +-pi, and clamp of the start heading
    logic signed [VelW+TimeW:0] w_wdt;
    logic signed [HdgW+2:0]     w_h;
    logic signed [HdgW+2:0]     w_hw;
    logic signed [HdgW-1:0]     w_hsat;
    logic signed [HdgW-1:0]     w_start_sat;
    assign w_wdt = (r_item.yaw_rate * $signed({1'b0, r_item.elapsed})) + 33'sd16384;
    assign w_h   = (HdgW+3)'(r_hdg) + (HdgW+3)'(w_wdt >>> 15);
    always_comb begin
        w_hw = w_h;
        if (w_h < -(HdgW+3)'(PI_Q13))     w_hw = w_h + (HdgW+3)'(TWO_PI_Q13);
        else if (w_h > (HdgW+3)'(PI_Q13)) w_hw = w_h - (HdgW+3)'(TWO_PI_Q13);
        if (w_hw > (HdgW+3)'(PI_Q13))       w_hsat = PI_Q13;
        else if (w_hw < -(HdgW+3)'(PI_Q13)) w_hsat = -PI_Q13;
        else                                w_hsat = w_hw[HdgW-1:0];
        if (r_start_hdg > PI_Q13)       w_start_sat = PI_Q13;
        else if (r_start_hdg < -PI_Q13) w_start_sat = -PI_Q13;
        else                            w_start_sat = r_start_hdg;
    end

    // Saturating position add of the rounded step
    logic signed [PosW+1:0] w_qs, w_psum;
    logic signed [PosW-1:0] w_pnew;
    assign w_qs = r_dneg ? -$signed({2'b0, r_num[PosW-1:0]})
                         : $signed({2'b0, r_num[PosW-1:0]});
    assign w_psum = (PosW+2)'(r_axis ? r_pos_y : r_pos_x) + w_qs;
    always_comb begin
        if (r_num[ProdW-1:PosW] != '0)
            w_pnew = r_dneg ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
        else if (w_psum > (PosW+2)'(32'sh7fffffff))
            w_pnew = {1'b0, {(PosW-1){1'b1}}};
        else if (w_psum < -(PosW+2)'(34'sh80000000))
            w_pnew = {1'b1, {(PosW-1){1'b0}}};
        else
            w_pnew = w_psum[PosW-1:0];
    end

    assign in_ch.ready  = (r_state == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_out;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start_x <= RST_START_X;
            r_start_y <= RST_START_Y;
            r_start_hdg <= RST_START_HDG;
            r_dt_limit <= RST_DT_LIMIT;
            r_pos_x <= RST_START_X;
            r_pos_y <= RST_START_Y;
            r_hdg <= RST_START_HDG;
            r_ovalid <= 1'b0;
        end else begin
            if (cfg_ch.valid) begin
                case (cfg_ch.data.index)
                    REG_START_X:   r_start_x <= cfg_ch.data.data;
                    REG_START_Y:   r_start_y <= cfg_ch.data.data;
                    REG_START_HDG: r_start_hdg <= cfg_ch.data.data[HdgW-1:0];
                    REG_DT_LIMIT:  r_dt_limit <= cfg_ch.data.data[TimeW-1:0];
                    default: ;
                endcase
            end
            // Load a new result or drop the one just taken
            if (r_state == S_OUT && (!r_ovalid || out_ch.ready))
                r_ovalid <= 1'b1;
            else if (out_ch.ready)
                r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_item <= in_ch.data;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_item.opcode == OP_RESTART) begin
                        r_skip <= 1'b0;
                        r_pos_x <= r_start_x;
                        r_pos_y <= r_start_y;
                        r_hdg <= w_start_sat;
                        r_state <= S_CS2;
                    end else if (r_item.elapsed > r_dt_limit) begin
                        r_skip <= 1'b1;
                        r_state <= S_CS2;
                    end else begin
                        r_skip <= 1'b0;
                        r_state <= S_CS1;
                    end
                end
                S_CS1: r_state <= S_WAIT1;
                S_WAIT1: begin
                    if (w_cs_done) begin
                        r_sin <= w_sin;
                        r_cos <= w_cos;
                        r_axis <= 1'b0;
                        r_mstep <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    case (r_mstep)
                        2'd0: begin r_acc <= AccW'(w_vprod); r_mstep <= 2'd1; end
                        2'd1: begin r_acc <= r_acc + AccW'(w_vprod); r_mstep <= 2'd2; end
                        default: begin
                            r_dneg <= w_tprod[TProdW-1];
                            r_num <= ProdW'(w_tprod[TProdW-1] ? -w_tprod : w_tprod);
                            r_dstep <= 1'b0;
                            r_state <= S_DIV;
                        end
                    endcase
                end
                S_DIV: begin
                    // Magnitude rounded half up, sign applied in the add
                    if (!r_dstep) begin
                        r_num <= ProdW'(w_dn);
                        r_dstep <= 1'b1;
                    end else begin
                        r_num <= ProdW'(w_dq);
                        r_state <= S_HDG;
                    end
                end
                S_HDG: begin
                    if (!r_axis) begin
                        r_pos_x <= w_pnew;
                        r_axis <= 1'b1;
                        r_mstep <= 2'd0;
                        r_state <= S_MUL;
                    end else begin
                        r_pos_y <= w_pnew;
                        r_hdg <= w_hsat;
                        r_state <= S_CS2;
                    end
                end
                S_CS2: r_state <= S_WAIT2;
                S_WAIT2: begin
                    if (w_cs_done)
                        r_state <= S_OUT;
                end
                S_OUT: begin
                    // Hold until the result register is free
                    if (!r_ovalid || out_ch.ready) begin
                        r_out.pos_x <= r_pos_x;
                        r_out.pos_y <= r_pos_y;
                        r_out.heading <= r_hdg;
                        r_out.quat_z <= w_sin;
                        r_out.quat_w <= w_cos;
                        r_out.skipped <= r_skip;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Heading stays within +-pi
    a_hdg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_hdg <= PI_Q13 && r_hdg >= -PI_Q13))
        else $error("heading out of range");
    // No new input while a transaction is in progress
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !in_ch.ready)
        else $error("ready while busy");
    // Held result stays put until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !out_ch.ready) |=> $stable(r_out))
        else $error("result changed while stalled");

endmodule

>>> design/ppi_cordic.sv
// ----------------------------------------------------------------------------
// Planar pose integrator CORDIC
// Iterative rotation CORDIC: one micro-rotation a cycle, Q1.14 sine/cosine.
// ----------------------------------------------------------------------------
module ppi_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [ppi_pkg::CordW-1:0]    i_angle,
    output logic                                o_done,
    output logic signed [ppi_pkg::QW-1:0]       o_sin,
    output logic signed [ppi_pkg::QW-1:0]       o_cos
);
    import ppi_pkg::*;

    logic                    r_busy;
    logic [IterW-1:0]        r_iter;
    logic signed [CordW-1:0] r_x, r_y, r_z;
    logic                    r_neg;
    logic                    r_done;

    logic signed [CordW-1:0] n_z0;
    logic                    n_neg0;
    logic signed [CordW-1:0] w_xs, w_ys;
    logic signed [CordW-1:0] w_xr, w_yr;
    logic signed [QW-1:0]    w_c, w_s;

    // Fold the angle into +-pi/2
    always_comb begin
        n_z0 = i_angle;
        n_neg0 = 1'b0;
        if (i_angle > HALF_PI_Q16) begin
            n_z0 = i_angle - PI_Q16;
            n_neg0 = 1'b1;
        end else if (i_angle < -HALF_PI_Q16) begin
            n_z0 = i_angle + PI_Q16;
            n_neg0 = 1'b1;
        end
    end

    assign w_xs = r_x >>> r_iter;
    assign w_ys = r_y >>> r_iter;

    // Advance one micro-rotation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
                r_x <= CORDIC_GAIN;
                r_y <= '0;
                r_z <= n_z0;
                r_neg <= n_neg0;
            end else if (r_busy) begin
                if (!r_z[CordW-1]) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - atan_q16(r_iter);
                end else begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + atan_q16(r_iter);
                end
                r_iter <= r_iter + 1'b1;
                if (r_iter == IterW'(CordIter - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Round to Q1.14, clamp, apply the half-turn sign
    assign w_xr = (r_x + CordW'(2)) >>> 2;
    assign w_yr = (r_y + CordW'(2)) >>> 2;
    always_comb begin
        if (w_xr > CordW'(ONE_Q14))       w_c = ONE_Q14;
        else if (w_xr < -CordW'(ONE_Q14)) w_c = -ONE_Q14;
        else                              w_c = w_xr[QW-1:0];
        if (w_yr > CordW'(ONE_Q14))       w_s = ONE_Q14;
        else if (w_yr < -CordW'(ONE_Q14)) w_s = -ONE_Q14;
        else                              w_s = w_yr[QW-1:0];
    end
    assign o_cos  = r_neg ? -w_c : w_c;
    assign o_sin  = r_neg ? -w_s : w_s;
    assign o_done = r_done;

endmodule
